### sv/rbe_pkg.sv
// ----------------------------------------------------------------------------
// rbe_pkg: shared types for the rigid body Euler step
// Operation codes and request/response bundles of the serial arithmetic unit,
// plus the configuration register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package rbe_pkg;

	// Operations of the shared serial unit.
	typedef enum logic [1:0] {
		OP_MUL  = 2'd0,
		OP_DIV  = 2'd1,
		OP_SQRT = 2'd2
	} arith_op_t;

	// Request from the sequencer: magnitudes only, signs are handled outside.
	typedef struct packed {
		logic      start;
		arith_op_t op;
		logic [63:0] a;   // multiplicand, dividend or radicand
		logic [32:0] b;   // multiplier or divisor
	} arith_req_t;

	// Response: done pulses for one cycle while res holds the result.
	typedef struct packed {
		logic        done;
		logic [63:0] res;
	} arith_rsp_t;

	// Configuration register indexes.
	localparam logic [2:0] CFG_MASS      = 3'd0;
	localparam logic [2:0] CFG_GRAVITY_X = 3'd1;
	localparam logic [2:0] CFG_GRAVITY_Y = 3'd2;
	localparam logic [2:0] CFG_GRAVITY_Z = 3'd3;
	localparam logic [2:0] CFG_FRICTION  = 3'd4;
	localparam logic [2:0] CFG_ACC_MODE  = 3'd5;
	localparam logic [2:0] CFG_FRIC_EN   = 3'd6;

endpackage

`default_nettype wire

### sv/rigid_body_euler_step.sv
// ----------------------------------------------------------------------------
// rigid_body_euler_step: semi-implicit Euler step with ground and friction
// Each input beat carries force, time step, ground flag and position of one
// body; the output beat carries the new position and velocity, and the
// velocity is kept as state for the next tick.
// ----------------------------------------------------------------------------
// Usage:
// - The slave channel takes one tick per beat; s_tready is high only while the
//   sequencer is idle, so one tick is worked on at a time.
// - The master channel presents the result from an output register. The next
//   tick is accepted while that result waits; it stalls in its final step
//   only if the previous result has still not been taken.
// - All multiplies, divides and square roots run through one shared serial
//   unit.
// - Configuration is written through cfg_we / cfg_index / cfg_data; the user
//   must do so only while idle, and nothing in the block enforces this.
// - Reset clears velocity to zero, loads the register defaults (mass 1.0,
//   gravity (0, -9.6, 0), friction 10.0, both flags off) and empties the
//   output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rigid_body_euler_step (
	input  wire          clk,
	input  wire          arst_n,
	// Configuration write port.
	input  wire          cfg_we,
	input  wire  [2:0]   cfg_index,
	input  wire  [31:0]  cfg_data,
	// Input channel.
	input  wire          s_tvalid,
	output logic         s_tready,
	// force_x, force_y, force_z, time_step, on_ground, pos_in_x, pos_in_y,
	// pos_in_z, zero pad
	input  wire  [215:0] s_tdata,
	// Output channel.
	output logic         m_tvalid,
	input  wire          m_tready,
	// pos_out_x, pos_out_y, pos_out_z, vel_out_x, vel_out_y, vel_out_z
	output logic [191:0] m_tdata
);

	typedef enum logic [21:0] {
		S_IDLE    = 22'h000001,
		S_ACC_DIV = 22'h000002,
		S_ACC_MUL = 22'h000004,
		S_AIR_ADD = 22'h000008,
		S_AIR_G   = 22'h000010,
		S_AIR_P   = 22'h000020,
		S_GND_ADD = 22'h000040,
		S_GSQ     = 22'h000080,
		S_GSQRT   = 22'h000100,
		S_GDIV    = 22'h000200,
		S_DOT     = 22'h000400,
		S_PROJ    = 22'h000800,
		S_FR      = 22'h001000,
		S_VSQ     = 22'h002000,
		S_LVSQRT  = 22'h004000,
		S_LHSQRT  = 22'h008000,
		S_LVV     = 22'h010000,
		S_FRLH    = 22'h020000,
		S_FMUL    = 22'h040000,
		S_FDIV    = 22'h080000,
		S_POS     = 22'h100000,
		S_OUT     = 22'h200000
	} state_t;

	// Sign handling helpers.
	function automatic logic [31:0] mag32(input logic signed [31:0] x);
		return x[31] ? (~x + 32'd1) : x;
	endfunction

	function automatic logic signed [65:0] sgn(input logic [63:0] m, input logic neg);
		logic signed [65:0] w;
		w = $signed({2'b00, m});
		return neg ? -w : w;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
		if (x > 66'sd2147483647) return 32'sh7fffffff;
		if (x < -66'sd2147483648) return 32'sh80000000;
		return x[31:0];
	endfunction

	// Configuration registers.
	logic [30:0]        mass_q;
	logic signed [31:0] grav_q [3];
	logic [30:0]        fric_q;
	logic               acc_mode_q;
	logic               fric_en_q;

	// Sequencer and working registers.
	state_t             state_q;
	logic [1:0]         lane_q;
	logic               launched_q;
	logic signed [31:0] vel_q [3];
	logic signed [31:0] force_q [3];
	logic signed [31:0] pos_q [3];
	logic signed [31:0] accel_q [3];
	logic signed [31:0] adt_q [3];
	logic signed [31:0] unit_q [3];
	logic [16:0]        dt_q;
	logic               ground_q;
	logic [63:0]        sum_q;
	logic [63:0]        hsum_q;
	logic signed [63:0] dot_q;
	logic [31:0]        glen_q;
	logic [31:0]        fr_q;
	logic [31:0]        lv_q;
	logic [31:0]        lh_q;
	logic [63:0]        tmp_q;
	logic [191:0]       out_q;
	logic               out_valid_q;

	rbe_pkg::arith_req_t req;
	rbe_pkg::arith_rsp_t rsp;

	logic        op_state;
	logic        in_fire;
	logic        out_load;
	logic        last_lane;
	logic [63:0] res;
	logic [30:0] mass_eff;
	logic [63:0] dot_mag;
	logic        fr_stop;

	assign s_tready  = (state_q == S_IDLE);
	assign in_fire   = s_tvalid && s_tready;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_q;
	assign out_load  = (state_q == S_OUT) && (!out_valid_q || m_tready);
	assign last_lane = (lane_q == 2'd2);
	assign res       = rsp.res;
	assign mass_eff  = (mass_q == 31'd0) ? 31'd1 : mass_q;
	assign dot_mag   = dot_q[63] ? (~dot_q + 64'd1) : dot_q;
	assign fr_stop   = (lv_q == 32'd0) || (tmp_q <= res);

	// Operand selection for the serial unit.
	always_comb begin
		op_state = 1'b1;
		req.op   = rbe_pkg::OP_MUL;
		req.a    = '0;
		req.b    = '0;
		unique case (state_q)
			S_ACC_DIV: begin
				req.op = rbe_pkg::OP_DIV;
				req.a  = {16'd0, mag32(force_q[lane_q]), 16'd0};
				req.b  = {2'b00, mass_eff};
			end
			S_ACC_MUL: begin
				req.a = {32'd0, mag32(accel_q[lane_q])};
				req.b = {16'd0, dt_q};
			end
			S_AIR_G: begin
				req.a = {32'd0, mag32(grav_q[1])};
				req.b = {16'd0, dt_q};
			end
			S_AIR_P: begin
				req.a = {32'd0, mag32(vel_q[lane_q])};
				req.b = {16'd0, dt_q};
			end
			S_GSQ: begin
				req.a = {32'd0, mag32(grav_q[lane_q])};
				req.b = {1'b0, mag32(grav_q[lane_q])};
			end
			S_GSQRT: begin
				req.op = rbe_pkg::OP_SQRT;
				req.a  = sum_q;
			end
			S_GDIV: begin
				req.op = rbe_pkg::OP_DIV;
				req.a  = {2'b00, mag32(grav_q[lane_q]), 30'd0};
				req.b  = {1'b0, glen_q};
			end
			S_DOT: begin
				req.a = {32'd0, mag32(vel_q[lane_q])};
				req.b = {1'b0, mag32(unit_q[lane_q])};
			end
			S_PROJ: begin
				req.a = {30'd0, dot_mag[63:30]};
				req.b = {1'b0, mag32(unit_q[lane_q])};
			end
			S_FR: begin
				req.a = {33'd0, fric_q};
				req.b = {16'd0, dt_q};
			end
			S_VSQ: begin
				req.a = {32'd0, mag32(vel_q[lane_q])};
				req.b = {1'b0, mag32(vel_q[lane_q])};
			end
			S_LVSQRT: begin
				req.op = rbe_pkg::OP_SQRT;
				req.a  = sum_q;
			end
			S_LHSQRT: begin
				req.op = rbe_pkg::OP_SQRT;
				req.a  = hsum_q;
			end
			S_LVV: begin
				req.a = {32'd0, lv_q};
				req.b = {1'b0, lv_q};
			end
			S_FRLH: begin
				req.a = {32'd0, fr_q};
				req.b = {1'b0, lh_q};
			end
			S_FMUL: begin
				req.a = {32'd0, mag32(vel_q[lane_q])};
				req.b = {1'b0, fr_q};
			end
			S_FDIV: begin
				req.op = rbe_pkg::OP_DIV;
				req.a  = tmp_q;
				req.b  = {1'b0, lv_q};
			end
			default: op_state = 1'b0;
		endcase
		req.start = op_state && !launched_q;
	end

	rbe_arith u_arith (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mass_q     <= 31'd65536;
			grav_q[0]  <= 32'sd0;
			grav_q[1]  <= -32'sd629146;
			grav_q[2]  <= 32'sd0;
			fric_q     <= 31'd655360;
			acc_mode_q <= 1'b0;
			fric_en_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rbe_pkg::CFG_MASS:      mass_q     <= cfg_data[30:0];
				rbe_pkg::CFG_GRAVITY_X: grav_q[0]  <= cfg_data;
				rbe_pkg::CFG_GRAVITY_Y: grav_q[1]  <= cfg_data;
				rbe_pkg::CFG_GRAVITY_Z: grav_q[2]  <= cfg_data;
				rbe_pkg::CFG_FRICTION:  fric_q     <= cfg_data[30:0];
				rbe_pkg::CFG_ACC_MODE:  acc_mode_q <= cfg_data[0];
				rbe_pkg::CFG_FRIC_EN:   fric_en_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Sequencer and datapath. Working registers other than velocity carry no reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			lane_q      <= 2'd0;
			launched_q  <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 3; i++) vel_q[i] <= 32'sd0;
		end else begin
			// Output register: a new result replaces a taken one in the same cycle.
			if (out_load) out_valid_q <= 1'b1;
			else if (m_tvalid && m_tready) out_valid_q <= 1'b0;

			// Launch handshake with the serial unit.
			if (req.start) launched_q <= 1'b1;
			else if (rsp.done) launched_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						force_q[0] <= s_tdata[31:0];
						force_q[1] <= s_tdata[63:32];
						force_q[2] <= s_tdata[95:64];
						dt_q       <= s_tdata[112:96];
						ground_q   <= s_tdata[113];
						pos_q[0]   <= s_tdata[145:114];
						pos_q[1]   <= s_tdata[177:146];
						pos_q[2]   <= s_tdata[209:178];
						lane_q     <= 2'd0;
						state_q    <= S_ACC_DIV;
					end
				end
				// Acceleration, truncated toward zero.
				S_ACC_DIV: begin
					if (rsp.done) begin
						accel_q[lane_q] <= sat32(sgn(res, force_q[lane_q][31]));
						state_q         <= S_ACC_MUL;
					end
				end
				S_ACC_MUL: begin
					if (rsp.done) begin
						adt_q[lane_q] <= sat32(sgn({16'd0, res[63:16]}, accel_q[lane_q][31]));
						if (last_lane) begin
							lane_q  <= 2'd0;
							state_q <= ground_q ? S_GND_ADD : S_AIR_ADD;
						end else begin
							lane_q  <= lane_q + 2'd1;
							state_q <= S_ACC_DIV;
						end
					end
				end
				// Airborne path.
				S_AIR_ADD: begin
					for (int i = 0; i < 3; i++)
						vel_q[i] <= sat32(66'(vel_q[i]) + 66'(adt_q[i]));
					state_q <= S_AIR_G;
				end
				S_AIR_G: begin
					if (rsp.done) begin
						vel_q[1] <= sat32(66'(vel_q[1]) +
							sgn({16'd0, res[63:16]}, grav_q[1][31]));
						lane_q   <= 2'd0;
						state_q  <= S_AIR_P;
					end
				end
				S_AIR_P: begin
					if (rsp.done) begin
						pos_q[lane_q] <= sat32(66'(pos_q[lane_q]) +
							sgn({16'd0, res[63:16]}, vel_q[lane_q][31]));
						lane_q  <= last_lane ? 2'd0 : lane_q + 2'd1;
						state_q <= last_lane ? S_OUT : S_AIR_P;
					end
				end
				// Grounded path: replace velocity, or accumulate it with y zeroed.
				S_GND_ADD: begin
					for (int i = 0; i < 3; i++) begin
						if (!acc_mode_q) vel_q[i] <= adt_q[i];
						else if (i == 1) vel_q[i] <= 32'sd0;
						else vel_q[i] <= sat32(66'(vel_q[i]) + 66'(adt_q[i]));
					end
					sum_q   <= '0;
					lane_q  <= 2'd0;
					state_q <= S_GSQ;
				end
				// Length of gravity.
				S_GSQ: begin
					if (rsp.done) begin
						sum_q   <= sum_q + res;
						lane_q  <= last_lane ? 2'd0 : lane_q + 2'd1;
						state_q <= last_lane ? S_GSQRT : S_GSQ;
					end
				end
				S_GSQRT: begin
					if (rsp.done) begin
						glen_q  <= res[31:0];
						dot_q   <= '0;
						state_q <= S_GDIV;
					end
				end
				// Unit gravity in Q2.30; zero gravity gives a zero vector.
				S_GDIV: begin
					if (rsp.done) begin
						unit_q[lane_q] <= (glen_q == 32'd0) ? 32'sd0 :
							32'(sgn(res, grav_q[lane_q][31]));
						lane_q  <= last_lane ? 2'd0 : lane_q + 2'd1;
						state_q <= last_lane ? S_DOT : S_GDIV;
					end
				end
				S_DOT: begin
					if (rsp.done) begin
						dot_q <= dot_q + 64'(sgn(res, vel_q[lane_q][31] ^ unit_q[lane_q][31]));
						lane_q  <= last_lane ? 2'd0 : lane_q + 2'd1;
						state_q <= last_lane ? S_PROJ : S_DOT;
					end
				end
				// Remove the component along gravity.
				S_PROJ: begin
					if (rsp.done) begin
						vel_q[lane_q] <= sat32(66'(vel_q[lane_q]) -
							sgn({30'd0, res[63:30]}, unit_q[lane_q][31] ^ dot_q[63]));
						lane_q <= last_lane ? 2'd0 : lane_q + 2'd1;
						if (last_lane) state_q <= fric_en_q ? S_FR : S_POS;
					end
				end
				// Friction.
				S_FR: begin
					if (rsp.done) begin
						fr_q    <= res[47:16];
						sum_q   <= '0;
						hsum_q  <= '0;
						lane_q  <= 2'd0;
						state_q <= S_VSQ;
					end
				end
				S_VSQ: begin
					if (rsp.done) begin
						sum_q <= sum_q + res;
						if (lane_q != 2'd1) hsum_q <= hsum_q + res;
						lane_q  <= last_lane ? 2'd0 : lane_q + 2'd1;
						state_q <= last_lane ? S_LVSQRT : S_VSQ;
					end
				end
				S_LVSQRT: begin
					if (rsp.done) begin
						lv_q    <= res[31:0];
						state_q <= S_LHSQRT;
					end
				end
				S_LHSQRT: begin
					if (rsp.done) begin
						lh_q    <= res[31:0];
						state_q <= S_LVV;
					end
				end
				S_LVV: begin
					if (rsp.done) begin
						tmp_q   <= res;
						state_q <= S_FRLH;
					end
				end
				// Stop the body when friction outweighs its speed.
				S_FRLH: begin
					if (rsp.done) begin
						lane_q <= 2'd0;
						if (fr_stop) begin
							for (int i = 0; i < 3; i++) vel_q[i] <= 32'sd0;
							state_q <= S_POS;
						end else begin
							state_q <= S_FMUL;
						end
					end
				end
				S_FMUL: begin
					if (rsp.done) begin
						tmp_q   <= res;
						state_q <= S_FDIV;
					end
				end
				// Slow the horizontal axes toward zero.
				S_FDIV: begin
					if (rsp.done) begin
						vel_q[lane_q] <= sat32(66'(vel_q[lane_q]) +
							sgn({31'd0, res[32:0]}, !vel_q[lane_q][31]));
						lane_q  <= last_lane ? 2'd0 : 2'd2;
						state_q <= last_lane ? S_POS : S_FMUL;
					end
				end
				S_POS: begin
					for (int i = 0; i < 3; i++)
						pos_q[i] <= sat32(66'(pos_q[i]) + 66'(vel_q[i]));
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_load) begin
						out_q       <= {vel_q[2], vel_q[1], vel_q[0],
							pos_q[2], pos_q[1], pos_q[0]};
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// An accepted beat takes the sequencer out of idle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !s_tready) else $error("still ready after accept");

	// The serial unit only answers operations that were launched.
	a_done_launched: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> (launched_q && op_state)) else $error("unexpected done");

	// A finished tick waits while the previous result is still held.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && m_tvalid && !m_tready) |=> (state_q == S_OUT && m_tvalid))
		else $error("result overwritten under stall");

endmodule

`default_nettype wire

### sv/rbe_arith.sv
// ----------------------------------------------------------------------------
// rbe_arith: serial multiply, divide and square root unit
// One bit of the multiplier, one quotient bit or one root bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rbe_arith (
	input  wire                 clk,
	input  wire                 arst_n,
	input  rbe_pkg::arith_req_t req,
	output rbe_pkg::arith_rsp_t rsp
);

	rbe_pkg::arith_op_t op_q;
	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [63:0] acc_q;
	logic [63:0] x_q;
	logic [32:0] y_q;

	logic [33:0] div_rem;
	logic        div_ge;
	logic [34:0] sq_rem;
	logic [34:0] sq_trial;
	logic        sq_ge;

	// One divide step and one square root step.
	always_comb begin
		div_rem  = {acc_q[32:0], x_q[63]};
		div_ge   = div_rem >= {1'b0, y_q};
		sq_rem   = {acc_q[32:0], x_q[63:62]};
		sq_trial = {1'b0, y_q[31:0], 2'b01};
		sq_ge    = sq_rem >= sq_trial;
	end

	// Control flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				unique case (req.op)
					rbe_pkg::OP_MUL:  cnt_q <= 6'd32;
					rbe_pkg::OP_DIV:  cnt_q <= 6'd63;
					rbe_pkg::OP_SQRT: cnt_q <= 6'd31;
					default:          cnt_q <= 6'd0;
				endcase
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (req.start) begin
			op_q  <= req.op;
			acc_q <= '0;
			x_q   <= req.a;
			y_q   <= (req.op == rbe_pkg::OP_SQRT) ? 33'd0 : req.b;
		end else if (busy_q) begin
			unique case (op_q)
				rbe_pkg::OP_MUL: begin
					if (y_q[0]) acc_q <= acc_q + x_q;
					x_q <= {x_q[62:0], 1'b0};
					y_q <= {1'b0, y_q[32:1]};
				end
				rbe_pkg::OP_DIV: begin
					acc_q <= {30'd0, div_ge ? (div_rem - {1'b0, y_q}) : div_rem};
					x_q   <= {x_q[62:0], div_ge};
				end
				rbe_pkg::OP_SQRT: begin
					acc_q <= {29'd0, sq_ge ? (sq_rem - sq_trial) : sq_rem};
					y_q   <= {y_q[31:0], sq_ge};
					x_q   <= {x_q[61:0], 2'b00};
				end
				default: ;
			endcase
		end
	end

	// Result selection.
	always_comb begin
		rsp.done = done_q;
		unique case (op_q)
			rbe_pkg::OP_MUL:  rsp.res = acc_q;
			rbe_pkg::OP_DIV:  rsp.res = x_q;
			rbe_pkg::OP_SQRT: rsp.res = {31'd0, y_q};
			default:          rsp.res = acc_q;
		endcase
	end

	// A new operation never starts while one is still running.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q) else $error("start while busy");

	// The last iteration is always followed by a done pulse.
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !req.start && cnt_q == 6'd0) |=> (done_q && !busy_q))
		else $error("missing done pulse");

endmodule

`default_nettype wire
